[rtl/core/qse_pkg.sv]
// ----------------------------------------------------------------------------
// qse_pkg
// shared constants and types of the quicksort engine
// ----------------------------------------------------------------------------
`default_nettype none

package qse_pkg;

   localparam int QSE_CAPACITY   = 64;
   localparam int QSE_VALUE_BITS = 32;
   localparam int DATA_BITS      = 32;
   localparam int IDX_BITS       = 6;
   localparam int RANGE_BITS     = 2 * IDX_BITS;

   typedef struct packed {
      logic load;
      logic last;
      logic over;
   } out_ctl_type;

endpackage

`default_nettype wire

[rtl/core/qse_store.sv]
// ----------------------------------------------------------------------------
// qse_store
// element memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module qse_store #(
   parameter int DEPTH = qse_pkg::QSE_CAPACITY,
   parameter int WIDTH = qse_pkg::QSE_VALUE_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] ra_addr,
   input  wire logic [$clog2(DEPTH)-1:0] rb_addr,
   output logic      [WIDTH-1:0]         ra_data,
   output logic      [WIDTH-1:0]         rb_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] ra_data_ff;
   logic [WIDTH-1:0] rb_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      ra_data_ff <= store_ff[ra_addr];
      rb_data_ff <= store_ff[rb_addr];
   end

   assign ra_data = ra_data_ff;
   assign rb_data = rb_data_ff;

endmodule

`default_nettype wire

[rtl/core/qse_stack.sv]
// ----------------------------------------------------------------------------
// qse_stack
// range stack memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module qse_stack #(
   parameter int DEPTH = qse_pkg::QSE_CAPACITY
) (
   input  wire logic                             clock,
   input  wire logic                             we,
   input  wire logic [$clog2(DEPTH)-1:0]         waddr,
   input  wire logic [qse_pkg::RANGE_BITS-1:0]   wdata,
   input  wire logic [$clog2(DEPTH)-1:0]         raddr,
   output logic      [qse_pkg::RANGE_BITS-1:0]   rdata
);

   logic [qse_pkg::RANGE_BITS-1:0] stack_ff [DEPTH];
   logic [qse_pkg::RANGE_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         stack_ff[waddr] <= wdata;
      end
      rdata_ff <= stack_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[rtl/core/qse_seq.sv]
// ----------------------------------------------------------------------------
// qse_seq
// sequencer: loads the set, runs the partition passes with one shared
// compare unit, and reads the sorted set out
// ----------------------------------------------------------------------------
`default_nettype none

module qse_seq #(
   parameter int CAPACITY   = qse_pkg::QSE_CAPACITY,
   parameter int VALUE_BITS = qse_pkg::QSE_VALUE_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [qse_pkg::DATA_BITS-1:0]     req_value,
   input  wire logic                              req_last,
   output logic                                   st_we,
   output logic      [$clog2(CAPACITY)-1:0]       st_waddr,
   output logic      [VALUE_BITS-1:0]             st_wdata,
   output logic      [$clog2(CAPACITY)-1:0]       st_ra_addr,
   output logic      [$clog2(CAPACITY)-1:0]       st_rb_addr,
   input  wire logic [VALUE_BITS-1:0]             st_ra_data,
   input  wire logic [VALUE_BITS-1:0]             st_rb_data,
   output logic                                   sk_we,
   output logic      [$clog2(CAPACITY)-1:0]       sk_waddr,
   output logic      [qse_pkg::RANGE_BITS-1:0]    sk_wdata,
   output logic      [$clog2(CAPACITY)-1:0]       sk_raddr,
   input  wire logic [qse_pkg::RANGE_BITS-1:0]    sk_rdata,
   input  wire logic                              out_free,
   output qse_pkg::out_ctl_type                   out_ctl,
   output logic      [qse_pkg::DATA_BITS-1:0]     out_value
);

   localparam int IW  = $clog2(CAPACITY);
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int XB  = qse_pkg::IDX_BITS;
   localparam int DB  = qse_pkg::DATA_BITS;

   localparam logic [3:0] S_LOAD  = 4'd0;
   localparam logic [3:0] S_INIT  = 4'd1;
   localparam logic [3:0] S_POP   = 4'd2;
   localparam logic [3:0] S_POPW  = 4'd3;
   localparam logic [3:0] S_PIV   = 4'd4;
   localparam logic [3:0] S_SCAN  = 4'd5;
   localparam logic [3:0] S_CMP   = 4'd6;
   localparam logic [3:0] S_SWAP  = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;
   localparam logic [3:0] S_FIN2  = 4'd9;
   localparam logic [3:0] S_PUSH1 = 4'd10;
   localparam logic [3:0] S_PUSH2 = 4'd11;
   localparam logic [3:0] S_ORD   = 4'd12;
   localparam logic [3:0] S_OLD   = 4'd13;

   logic [3:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  drop_ff, drop_in;
   logic [CW-1:0]         sp_ff, sp_in;
   logic [XB-1:0]         lo_ff, lo_in;
   logic [XB-1:0]         hi_ff, hi_in;
   logic [XB-1:0]         p_ff, p_in;
   logic [XB-1:0]         j_ff, j_in;
   logic [IW-1:0]         k_ff, k_in;
   logic [VALUE_BITS-1:0] pivot_ff, pivot_in;
   logic [VALUE_BITS-1:0] tmp_ff, tmp_in;

   logic [VALUE_BITS+DB-1:0] in_ext;
   logic [VALUE_BITS+DB-1:0] out_ext;
   logic [XB-1:0]            pop_lo;
   logic [XB-1:0]            pop_hi;
   logic                     not_greater;
   logic                     sk_push;
   logic                     k_last;

   assign in_ext      = {{VALUE_BITS{1'b0}}, req_value};
   assign out_ext     = {{DB{1'b0}}, st_ra_data};
   assign out_value   = out_ext[DB-1:0];
   assign pop_lo      = sk_rdata[qse_pkg::RANGE_BITS-1:XB];
   assign pop_hi      = sk_rdata[XB-1:0];
   assign not_greater = $signed(st_ra_data) <= $signed(pivot_ff);
   assign sk_push     = sp_ff < CW'(CAPACITY);
   assign k_last      = (CW'(k_ff) + CW'(1)) == count_ff;
   assign req_ready   = state_ff == S_LOAD;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      drop_in    = drop_ff;
      sp_in      = sp_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      p_in       = p_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      pivot_in   = pivot_ff;
      tmp_in     = tmp_ff;
      st_we      = 1'b0;
      st_waddr   = count_ff[IW-1:0];
      st_wdata   = in_ext[VALUE_BITS-1:0];
      st_ra_addr = j_ff[IW-1:0];
      st_rb_addr = p_ff[IW-1:0];
      sk_we      = 1'b0;
      sk_waddr   = sp_ff[IW-1:0];
      sk_wdata   = {XB'(0), XB'(count_ff - CW'(1))};
      sk_raddr   = sp_ff[IW-1:0];
      out_ctl    = '0;
      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               if (count_ff < CW'(CAPACITY)) begin
                  st_we    = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_last) begin
                  state_in = S_INIT;
               end
            end
         end
         S_INIT: begin
            sk_waddr = '0;
            if (count_ff >= CW'(2)) begin
               sk_we = 1'b1;
               sp_in = CW'(1);
            end else begin
               sp_in = '0;
            end
            state_in = S_POP;
         end
         S_POP: begin
            if (sp_ff == '0) begin
               k_in     = '0;
               state_in = S_ORD;
            end else begin
               sp_in    = sp_ff - CW'(1);
               sk_raddr = IW'(sp_ff - CW'(1));
               state_in = S_POPW;
            end
         end
         S_POPW: begin
            lo_in = pop_lo;
            hi_in = pop_hi;
            if ((pop_lo >= pop_hi) || ({1'b0, pop_hi} >= (XB + 1)'(CAPACITY))) begin
               state_in = S_POP;
            end else begin
               p_in       = pop_lo;
               j_in       = pop_lo;
               st_ra_addr = pop_hi[IW-1:0];
               state_in   = S_PIV;
            end
         end
         S_PIV: begin
            pivot_in = st_ra_data;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (j_ff < hi_ff) begin
               st_ra_addr = j_ff[IW-1:0];
               st_rb_addr = p_ff[IW-1:0];
               state_in   = S_CMP;
            end else begin
               st_ra_addr = p_ff[IW-1:0];
               st_rb_addr = hi_ff[IW-1:0];
               state_in   = S_FIN;
            end
         end
         S_CMP: begin
            if (not_greater) begin
               st_we    = 1'b1;
               st_waddr = p_ff[IW-1:0];
               st_wdata = st_ra_data;
               tmp_in   = st_rb_data;
               state_in = S_SWAP;
            end else begin
               j_in     = j_ff + XB'(1);
               state_in = S_SCAN;
            end
         end
         S_SWAP: begin
            st_we    = 1'b1;
            st_waddr = j_ff[IW-1:0];
            st_wdata = tmp_ff;
            p_in     = p_ff + XB'(1);
            j_in     = j_ff + XB'(1);
            state_in = S_SCAN;
         end
         S_FIN: begin
            st_we    = 1'b1;
            st_waddr = p_ff[IW-1:0];
            st_wdata = st_rb_data;
            tmp_in   = st_ra_data;
            state_in = S_FIN2;
         end
         S_FIN2: begin
            st_we    = 1'b1;
            st_waddr = hi_ff[IW-1:0];
            st_wdata = tmp_ff;
            state_in = S_PUSH1;
         end
         S_PUSH1: begin
            sk_wdata = {p_ff + XB'(1), hi_ff};
            if ((({1'b0, p_ff} + (XB + 1)'(1)) < {1'b0, hi_ff}) && sk_push) begin
               sk_we = 1'b1;
               sp_in = sp_ff + CW'(1);
            end
            state_in = S_PUSH2;
         end
         S_PUSH2: begin
            sk_wdata = {lo_ff, p_ff - XB'(1)};
            if ((p_ff > (lo_ff + XB'(1))) && sk_push) begin
               sk_we = 1'b1;
               sp_in = sp_ff + CW'(1);
            end
            state_in = S_POP;
         end
         S_ORD: begin
            st_ra_addr = k_ff;
            if (out_free) begin
               state_in = S_OLD;
            end
         end
         S_OLD: begin
            out_ctl.load = 1'b1;
            out_ctl.last = k_last;
            out_ctl.over = drop_ff;
            if (k_last) begin
               count_in = '0;
               drop_in  = 1'b0;
               k_in     = '0;
               state_in = S_LOAD;
            end else begin
               k_in     = k_ff + IW'(1);
               state_in = S_ORD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         drop_ff  <= 1'b0;
         sp_ff    <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
         sp_ff    <= sp_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      p_ff     <= p_in;
      j_ff     <= j_in;
      pivot_ff <= pivot_in;
      tmp_ff   <= tmp_in;
   end

endmodule

`default_nettype wire

[rtl/core/quicksort_engine.sv]
// ----------------------------------------------------------------------------
// quicksort_engine
// collects a set of signed values, sorts it in place by quicksort with
// last-element pivot partitioning and an explicit range stack, then
// streams the set out in ascending order
//
//   channel  dir  tdata                 tlast        tuser
//   req      in   value[31:0]           is_last      -
//   rsp      out  sorted_value[31:0]    end_of_set   overflowed
//
// load takes one word per cycle until the word with tlast
// sort: per range POP and POPW, a pivot read (PIV), SCAN and CMP per element
//   scanned plus SWAP per element moved, FIN/FIN2 place pivot, PUSH1/PUSH2 push
// readout: ORD and OLD per word, one element memory read port each
// reset clears control state only; element and range memories need no clear
// req_tready is low from the last word until the final result is loaded
// ----------------------------------------------------------------------------
`default_nettype none

module quicksort_engine #(
   parameter int CAPACITY   = qse_pkg::QSE_CAPACITY,
   parameter int VALUE_BITS = qse_pkg::QSE_VALUE_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [qse_pkg::DATA_BITS-1:0] req_tdata,   // value
   input  wire logic                          req_tlast,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [qse_pkg::DATA_BITS-1:0] rsp_tdata,   // sorted_value
   output logic                               rsp_tlast,
   output logic                               rsp_tuser    // overflowed
);

   localparam int IW = $clog2(CAPACITY);

   logic                           st_we;
   logic [IW-1:0]                  st_waddr;
   logic [VALUE_BITS-1:0]          st_wdata;
   logic [IW-1:0]                  st_ra_addr;
   logic [IW-1:0]                  st_rb_addr;
   logic [VALUE_BITS-1:0]          st_ra_data;
   logic [VALUE_BITS-1:0]          st_rb_data;
   logic                           sk_we;
   logic [IW-1:0]                  sk_waddr;
   logic [qse_pkg::RANGE_BITS-1:0] sk_wdata;
   logic [IW-1:0]                  sk_raddr;
   logic [qse_pkg::RANGE_BITS-1:0] sk_rdata;
   logic                           out_free;
   qse_pkg::out_ctl_type           out_ctl;
   logic [qse_pkg::DATA_BITS-1:0]  out_value;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [qse_pkg::DATA_BITS-1:0]  rsp_data_ff;
   logic                           rsp_last_ff;
   logic                           rsp_user_ff;

   qse_store #(
      .DEPTH (CAPACITY),
      .WIDTH (VALUE_BITS)
   ) u_store (
      .clock   (clock),
      .we      (st_we),
      .waddr   (st_waddr),
      .wdata   (st_wdata),
      .ra_addr (st_ra_addr),
      .rb_addr (st_rb_addr),
      .ra_data (st_ra_data),
      .rb_data (st_rb_data)
   );

   qse_stack #(
      .DEPTH (CAPACITY)
   ) u_stack (
      .clock (clock),
      .we    (sk_we),
      .waddr (sk_waddr),
      .wdata (sk_wdata),
      .raddr (sk_raddr),
      .rdata (sk_rdata)
   );

   qse_seq #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_value  (req_tdata),
      .req_last   (req_tlast),
      .st_we      (st_we),
      .st_waddr   (st_waddr),
      .st_wdata   (st_wdata),
      .st_ra_addr (st_ra_addr),
      .st_rb_addr (st_rb_addr),
      .st_ra_data (st_ra_data),
      .st_rb_data (st_rb_data),
      .sk_we      (sk_we),
      .sk_waddr   (sk_waddr),
      .sk_wdata   (sk_wdata),
      .sk_raddr   (sk_raddr),
      .sk_rdata   (sk_rdata),
      .out_free   (out_free),
      .out_ctl    (out_ctl),
      .out_value  (out_value)
   );

   // output register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (out_ctl.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ctl.load) begin
         rsp_data_ff <= out_value;
         rsp_last_ff <= out_ctl.last;
         rsp_user_ff <= out_ctl.over;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_load_into_free_slot : assert property (@(posedge clock) disable iff (reset)
      out_ctl.load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten before its word was taken");

   a_busy_after_last : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("input accepted while sorting");

   a_ready_after_final : assert property (@(posedge clock) disable iff (reset)
      (out_ctl.load && out_ctl.last) |=> req_tready)
      else $error("not ready for a new set after the final result");
`endif

endmodule

`default_nettype wire
